/* rtl/bgnc_pkg.sv */
`timescale 1ns / 1ps

package bgnc_pkg;

    localparam int CFG_W   = 8;
    localparam int TDATA_W = 8;
    localparam int COUNT_W = 4;

    typedef enum logic
    {
        OP_CELL  = 1'b0,
        OP_DRAIN = 1'b1
    } op_t;

    // Neighbour-validity flags for the ages that may lie before the frame start.
    typedef struct packed
    {
        logic age_2w2;
        logic age_2w1;
        logic age_2w;
        logic age_w2;
    } age_valid_t;

endpackage

/* rtl/binary_grid_neighbour_count_core.sv */
`timescale 1ns / 1ps

// Channel   Dir  Bits  Contents (lowest bit first)
// s_*       in   8+1   tdata: cell_is_mine, zero pad; tuser: op
// m_*       out  8+1   tdata: center_is_mine, mine_count, zero pad; tlast: end_of_frame
// cfg_*     in   8     grid_width, written when cfg_we is high
//
// One request is accepted per clock while s_tready is high. A request's result passes
// through the read stage, where the history memory is read, to the output register.
// Reset clears control state only; the history memory keeps its contents and a fill
// count masks every entry not yet written in the current frame, so there is no clearing pass.
// s_tready falls only while the output register and the read stage both hold a result.
module binary_grid_neighbour_count_core
#(
    parameter int MAX_WIDTH = 128
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [bgnc_pkg::CFG_W-1:0]  cfg_wdata,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [bgnc_pkg::TDATA_W-1:0] s_tdata,  // [0] cell_is_mine
    input  logic                        s_tuser,   // [0] op
    output logic                        m_tvalid,
    input  logic                        m_tready,
    output logic [bgnc_pkg::TDATA_W-1:0] m_tdata,  // [0] center_is_mine, [4:1] mine_count
    output logic                        m_tlast
);

    import bgnc_pkg::*;

    localparam int WMAX  = (MAX_WIDTH < 255) ? MAX_WIDTH : 255;
    localparam int DEPTH = 2 * MAX_WIDTH + 3;
    localparam int PW    = $clog2(DEPTH);
    localparam int AW    = $clog2(2 * WMAX + 3);
    localparam int CW    = (WMAX > 1) ? $clog2(WMAX) : 1;
    localparam int DW    = $clog2(WMAX + 2);

    // Each entry holds the pushed cell and the two cells pushed before it.
    logic [2:0]         hist_mem [DEPTH];

    logic [CFG_W-1:0]   grid_width_reg;
    logic [PW-1:0]      head_reg;
    logic [CW-1:0]      col_reg;
    logic [AW-1:0]      items_reg;
    logic [DW-1:0]      drain_reg;
    logic               prev1_reg;
    logic               prev2_reg;

    logic               st_valid_reg;
    logic               st_emit_reg;
    logic               st_last_reg;
    logic               st_left_reg;
    logic               st_right_reg;
    logic [2:0]         st_nw_reg;
    age_valid_t         st_v_reg;
    logic [2:0]         rd_a_reg;
    logic [2:0]         rd_b_reg;

    logic               out_valid_reg;
    logic               out_center_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_last_reg;

    logic [CFG_W-1:0]   width_eff;
    logic [AW-1:0]      age_w;
    logic [AW-1:0]      age_w2;
    logic [AW-1:0]      age_2w;
    logic [AW-1:0]      age_2w1;
    logic [AW-1:0]      age_2w2;
    logic [CW-1:0]      col_cur;
    logic [CW-1:0]      col_next;
    logic [PW-1:0]      head_new;
    logic [PW-1:0]      addr_a;
    logic [PW-1:0]      addr_b;
    logic               is_drain;
    logic               cell_bit;
    logic               emit;
    logic               last;
    logic               has_left;
    logic               has_right;
    logic [2:0]         new_word;
    age_valid_t         age_v;
    logic [AW-1:0]      items_next;
    logic               s_acc;
    logic               out_free;
    logic               st_adv;
    logic [COUNT_W-1:0] count;

    function automatic logic [PW-1:0] rd_addr(input logic [PW-1:0] h, input logic [AW-1:0] age);
        logic [PW:0] diff;
        diff = {1'b0, h} - (PW+1)'(age);
        if (diff[PW])
        begin
            diff = diff + (PW+1)'(DEPTH);
        end
        return diff[PW-1:0];
    endfunction

    always_comb
    begin
        if (grid_width_reg == '0)
        begin
            width_eff = CFG_W'(1);
        end
        else if (int'(grid_width_reg) > WMAX)
        begin
            width_eff = CFG_W'(WMAX);
        end
        else
        begin
            width_eff = grid_width_reg;
        end
    end

    assign age_w   = AW'(width_eff);
    assign age_w2  = age_w + AW'(2);
    assign age_2w  = age_w << 1;
    assign age_2w1 = age_2w + AW'(1);
    assign age_2w2 = age_2w + AW'(2);

    // A column left over from a wider setting restarts the row.
    assign col_cur  = (CFG_W'(col_reg) >= width_eff) ? '0 : col_reg;
    assign col_next = ({1'b0, CFG_W'(col_cur)} + (CFG_W+1)'(1) >= {1'b0, width_eff})
                      ? '0 : col_cur + CW'(1);

    // The reported cell sits one row up and one column left of the incoming one, wrapping to the row end.
    assign has_right = (col_cur != '0);
    assign has_left  = (col_cur == '0) ? (width_eff > CFG_W'(1)) : (int'(col_cur) >= 2);

    assign is_drain = (op_t'(s_tuser) == OP_DRAIN) || (drain_reg != '0);
    assign cell_bit = is_drain ? 1'b0 : s_tdata[0];
    assign emit     = (items_reg > age_w);
    assign last     = is_drain && (int'(drain_reg) >= int'(width_eff));
    assign new_word = {prev2_reg, prev1_reg, cell_bit};

    // Ages beyond the fill count lie before the frame start and read as empty.
    assign age_v.age_w2  = (items_reg >= age_w2);
    assign age_v.age_2w  = (items_reg >= age_2w);
    assign age_v.age_2w1 = (items_reg >= age_2w1);
    assign age_v.age_2w2 = (items_reg >= age_2w2);

    assign items_next = (items_reg == '1) ? items_reg : items_reg + AW'(1);

    assign head_new = (head_reg == PW'(DEPTH - 1)) ? '0 : head_reg + PW'(1);
    assign addr_a   = rd_addr(head_new, age_w);
    assign addr_b   = rd_addr(head_new, age_2w);

    assign out_free = !out_valid_reg || m_tready;
    assign st_adv   = !st_emit_reg || out_free;
    assign s_tready = !st_valid_reg || st_adv;
    assign s_acc    = s_tvalid && s_tready;

    always_comb
    begin
        count = COUNT_W'(rd_b_reg[1] & st_v_reg.age_2w1) + COUNT_W'(st_nw_reg[1]);
        if (st_left_reg)
        begin
            count = count + COUNT_W'(rd_b_reg[2] & st_v_reg.age_2w2)
                          + COUNT_W'(rd_a_reg[2] & st_v_reg.age_w2)
                          + COUNT_W'(st_nw_reg[2]);
        end
        if (st_right_reg)
        begin
            count = count + COUNT_W'(rd_b_reg[0] & st_v_reg.age_2w)
                          + COUNT_W'(rd_a_reg[0])
                          + COUNT_W'(st_nw_reg[0]);
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_acc)
        begin
            hist_mem[head_new] <= new_word;
            rd_a_reg           <= hist_mem[addr_a];
            rd_b_reg           <= hist_mem[addr_b];
            st_nw_reg          <= new_word;
            st_v_reg           <= age_v;
            st_left_reg        <= has_left;
            st_right_reg       <= has_right;
            st_last_reg        <= last;
        end
        if (st_valid_reg && st_emit_reg && out_free)
        begin
            out_center_reg <= rd_a_reg[1];
            out_count_reg  <= rd_a_reg[1] ? '0 : count;
            out_last_reg   <= st_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_width_reg <= CFG_W'(1);
            head_reg       <= '0;
            col_reg        <= '0;
            items_reg      <= '0;
            drain_reg      <= '0;
            prev1_reg      <= 1'b0;
            prev2_reg      <= 1'b0;
            st_valid_reg   <= 1'b0;
            st_emit_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                grid_width_reg <= cfg_wdata;
            end
            if (s_acc)
            begin
                head_reg     <= head_new;
                st_valid_reg <= 1'b1;
                st_emit_reg  <= emit;
                if (last)
                begin
                    col_reg   <= '0;
                    items_reg <= '0;
                    drain_reg <= '0;
                    prev1_reg <= 1'b0;
                    prev2_reg <= 1'b0;
                end
                else
                begin
                    col_reg   <= col_next;
                    items_reg <= items_next;
                    drain_reg <= is_drain ? drain_reg + DW'(1) : drain_reg;
                    prev1_reg <= cell_bit;
                    prev2_reg <= prev1_reg;
                end
            end
            else if (st_adv)
            begin
                st_valid_reg <= 1'b0;
            end
            if (st_valid_reg && st_emit_reg && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = TDATA_W'({out_count_reg, out_center_reg});
    assign m_tlast  = out_last_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[4:1] <= COUNT_W'(8)))
        else $error("neighbour count above eight");

    assert property (@(posedge clk) disable iff (!rst_n)
        (s_acc && last) |=> (items_reg == '0 && drain_reg == '0 && col_reg == '0))
        else $error("frame state not cleared after the last request");

    assert property (@(posedge clk) disable iff (!rst_n)
        (st_valid_reg && !st_adv) |=> ($stable(rd_a_reg) && $stable(rd_b_reg)))
        else $error("history read data changed while the read stage was stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[0]) |-> (m_tdata[4:1] == '0))
        else $error("mine cell reported with a nonzero count");

endmodule
